// ----- rtl/pcnd_pkg.sv -----
// Shared types, constants and the code-suffix walk of the prefix-code nibble decoder.
// No dependencies; used by the front queue and the bit-serial back end.
package pcnd_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Zero count that marks end of stream.
    localparam logic [2:0] ZR_END = 3'd6;
    localparam logic [2:0] BIT_LAST = 3'd7;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BITS,
        PH_CLOSE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_entry;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

    // Result of walking one suffix bit.
    typedef struct packed {
        logic       more;
        logic       bad;
        logic [3:0] nib;
        logic [2:0] next_sp;
    } t_sfx;

    function automatic t_sfx sfx_step(input logic [2:0] zr, input logic [2:0] sp,
                                      input logic b);
        t_sfx r;
        r.more    = 1'b0;
        r.bad     = 1'b0;
        r.nib     = 4'h0;
        r.next_sp = sp;
        case (zr)
            3'd1: r.nib = b ? 4'hF : 4'h1;
            3'd2: r.nib = b ? 4'h8 : 4'h2;
            3'd3: r.nib = b ? 4'h7 : 4'hC;
            3'd4: begin
                case (sp)
                    3'd1: begin
                        r.more    = 1'b1;
                        r.next_sp = b ? 3'd2 : 3'd3;
                    end
                    3'd2: r.nib = b ? 4'h9 : 4'h4;
                    3'd3: begin
                        r.more    = 1'b1;
                        r.next_sp = b ? 3'd4 : 3'd5;
                    end
                    3'd4: r.nib = b ? 4'h5 : 4'hA;
                    3'd5: r.nib = b ? 4'hB : 4'h3;
                    default: r.bad = 1'b1;
                endcase
            end
            3'd5: begin
                case (sp)
                    3'd1: begin
                        r.more    = 1'b1;
                        r.next_sp = b ? 3'd2 : 3'd3;
                    end
                    3'd2: r.nib = b ? 4'hD : 4'hE;
                    3'd3: begin
                        if (b) begin
                            r.nib = 4'h6;
                        end else begin
                            r.bad = 1'b1;   // reserved code
                        end
                    end
                    default: r.bad = 1'b1;
                endcase
            end
            default: r.bad = 1'b1;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/pcnd_if.sv -----
// Valid/ready channel interfaces for compressed input bytes and decoded result items.
// Standalone; no package dependency.
interface pcnd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface pcnd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       final_item;

    modport source(output valid, output out_byte, output kind, output final_item,
                   input ready);
    modport sink(input valid, input out_byte, input kind, input final_item,
                 output ready);
endinterface

// ----- rtl/pcnd_front.sv -----
// Front end: accepts compressed bytes and holds them in a short queue for the back end.
// Depends on pcnd_pkg and pcnd_in_if.
module pcnd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pcnd_in_if.sink               i_in,
    output pcnd_pkg::t_q_head     o_head,
    input  logic                  i_pop
);

    pcnd_pkg::t_entry                r_mem [pcnd_pkg::Q_DEPTH];
    logic [pcnd_pkg::Q_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [pcnd_pkg::Q_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [pcnd_pkg::Q_CNT_W-1:0]    r_count, n_count;
    logic                            push;
    logic                            pop;

    assign i_in.ready   = (r_count != pcnd_pkg::Q_CNT_W'(pcnd_pkg::Q_DEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign pop          = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data_byte: i_in.data_byte, last_byte: i_in.last_byte};
        end
    end

endmodule

// ----- rtl/pcnd_back.sv -----
// Back end: walks queued bytes one code bit per cycle while the output is free, pairs
// nibbles into bytes and issues the closing status. Uses pcnd_pkg and pcnd_out_if.
module pcnd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcnd_pkg::t_q_head     i_head,
    output logic                  o_pop,
    pcnd_out_if.source            o_out
);

    pcnd_pkg::t_phase  r_phase, n_phase;
    logic [7:0]        r_shift, n_shift;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_last, n_last;
    logic [2:0]        r_zr, n_zr;
    logic [2:0]        r_sp, n_sp;
    logic [3:0]        r_hi, n_hi;
    logic              r_hh, n_hh;
    logic              r_stop, n_stop;
    logic              r_stat_v, n_stat_v;
    pcnd_pkg::t_kind   r_stat_k, n_stat_k;

    logic              r_ov, n_ov;
    logic [7:0]        r_ob, n_ob;
    pcnd_pkg::t_kind   r_ok, n_ok;
    logic              r_of, n_of;

    logic              cur_bit;
    logic [2:0]        zr_inc;
    pcnd_pkg::t_sfx    sfx;
    logic              out_free;
    logic              skip;
    logic              done_nib;
    logic [3:0]        nib;
    logic              emit;
    logic              step_ok;
    logic              end_byte;
    pcnd_pkg::t_kind   close_k;

    assign cur_bit  = r_shift[7];
    assign zr_inc   = r_zr + 3'd1;
    assign sfx      = pcnd_pkg::sfx_step(r_zr, r_sp, cur_bit);
    assign out_free = !r_ov || o_out.ready;
    // Once stopped or a status is known, the rest of the byte is dropped.
    assign skip     = r_stop || r_stat_v;
    assign done_nib = (r_sp == 3'd0) ? (cur_bit && (r_zr == 3'd0)) : (!sfx.more && !sfx.bad);
    assign nib      = (r_sp == 3'd0) ? 4'h0 : sfx.nib;
    assign emit     = done_nib && r_hh;
    assign step_ok  = !emit || out_free;
    assign end_byte = (r_phase == pcnd_pkg::PH_BITS)
                      && (skip || (step_ok && (r_cnt == pcnd_pkg::BIT_LAST)));
    assign o_pop    = i_head.valid && ((r_phase == pcnd_pkg::PH_IDLE)
                      || (end_byte && !r_last));

    always_comb begin
        if (r_stop) begin
            close_k = pcnd_pkg::KIND_ERR;
        end else if (r_stat_v) begin
            close_k = r_stat_k;
        end else if (r_zr == 3'd0 && r_sp == 3'd0 && !r_hh) begin
            close_k = pcnd_pkg::KIND_END;
        end else begin
            close_k = pcnd_pkg::KIND_ERR;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_zr     = r_zr;
        n_sp     = r_sp;
        n_hi     = r_hi;
        n_hh     = r_hh;
        n_stop   = r_stop;
        n_stat_v = r_stat_v;
        n_stat_k = r_stat_k;
        n_ov     = r_ov && !o_out.ready;
        n_ob     = r_ob;
        n_ok     = r_ok;
        n_of     = r_of;

        case (r_phase)
            pcnd_pkg::PH_IDLE: begin
            end
            pcnd_pkg::PH_BITS: begin
                if (!skip && step_ok) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_cnt   = r_cnt + 3'd1;
                    if (r_sp == 3'd0) begin
                        if (!cur_bit) begin
                            n_zr = zr_inc;
                            if (zr_inc >= pcnd_pkg::ZR_END) begin
                                if (r_last) begin
                                    n_stat_v = 1'b1;
                                    n_stat_k = r_hh ? pcnd_pkg::KIND_ERR : pcnd_pkg::KIND_END;
                                end else begin
                                    n_stop = 1'b1;
                                end
                            end
                        end else if (r_zr != 3'd0) begin
                            n_sp = 3'd1;
                        end
                    end else if (sfx.more) begin
                        n_sp = sfx.next_sp;
                    end else if (sfx.bad) begin
                        if (r_last) begin
                            n_stat_v = 1'b1;
                            n_stat_k = pcnd_pkg::KIND_ERR;
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                    if (done_nib) begin
                        n_zr = 3'd0;
                        n_sp = 3'd0;
                        if (r_hh) begin
                            n_hh = 1'b0;
                            n_ov = 1'b1;
                            n_ob = {r_hi, nib};
                            n_ok = pcnd_pkg::KIND_DATA;
                            n_of = 1'b0;
                        end else begin
                            n_hi = nib;
                            n_hh = 1'b1;
                        end
                    end
                end
                if (end_byte) begin
                    n_phase = r_last ? pcnd_pkg::PH_CLOSE : pcnd_pkg::PH_IDLE;
                end
            end
            pcnd_pkg::PH_CLOSE: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_ob     = 8'h00;
                    n_ok     = close_k;
                    n_of     = 1'b1;
                    n_zr     = 3'd0;
                    n_sp     = 3'd0;
                    n_hi     = 4'h0;
                    n_hh     = 1'b0;
                    n_stop   = 1'b0;
                    n_stat_v = 1'b0;
                    n_phase  = pcnd_pkg::PH_IDLE;
                end
            end
            default: n_phase = pcnd_pkg::PH_IDLE;
        endcase

        if (o_pop) begin
            n_shift = i_head.entry.data_byte;
            n_last  = i_head.entry.last_byte;
            n_cnt   = 3'd0;
            n_phase = pcnd_pkg::PH_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pcnd_pkg::PH_IDLE;
            r_zr     <= 3'd0;
            r_sp     <= 3'd0;
            r_hi     <= 4'h0;
            r_hh     <= 1'b0;
            r_stop   <= 1'b0;
            r_stat_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_zr     <= n_zr;
            r_sp     <= n_sp;
            r_hi     <= n_hi;
            r_hh     <= n_hh;
            r_stop   <= n_stop;
            r_stat_v <= n_stat_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_cnt    <= n_cnt;
        r_last   <= n_last;
        r_stat_k <= n_stat_k;
        r_ob     <= n_ob;
        r_ok     <= n_ok;
        r_of     <= n_of;
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_ob;
    assign o_out.kind       = r_ok;
    assign o_out.final_item = r_of;

endmodule

// ----- rtl/prefix_code_nibble_decoder.sv -----
// Prefix-code nibble decoder, top level: front queue feeding a bit-serial back end.
// Walks one code bit per cycle while the output is not stalled; once the stream has stopped or
// ended, the rest of a byte is dropped. A last byte adds the closing status, then a reload.
// A 4-entry queue decouples input. A data item is valid the cycle after its completing
// bit, which a byte reaches through the queue and the back end's shift register.
// Reset (synchronous, active low) empties the queue and clears the phase and decode state.
module prefix_code_nibble_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcnd_in_if.sink     i_in,
    pcnd_out_if.source  o_out
);

    pcnd_pkg::t_q_head head;
    logic              pop;

    pcnd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (head),
        .i_pop   (pop)
    );

    pcnd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
